@@ rtl/isc_pkg.sv @@
// shared types, widths and rounding helper for the isotropic stress block
`default_nettype none

package isc_pkg;

    localparam int StrainW  = 32;
    localparam int CrackW   = 17;
    localparam int ModW     = 24;
    localparam int C11W     = ModW + 2;
    localparam int DenW     = ModW + 1;
    localparam int NumW     = 2 * ModW + 3;
    localparam int FracE    = 16;
    localparam int DvdW     = NumW + FracE;
    localparam int DivCntW  = $clog2(DvdW);
    localparam int E16W     = 42;
    localparam int FullW    = C11W + 1 + StrainW;
    localparam int CplW     = ModW + 1 + StrainW;
    localparam int HiW      = E16W - FracE + StrainW;
    localparam int LoW      = FracE + StrainW;
    localparam int CrkW     = HiW + 1;
    localparam int AccW     = 61;
    localparam int FracS    = 30;
    localparam int StressW  = 32;

    localparam logic [CrackW-1:0] Uncracked = CrackW'(65536);

    localparam logic signed [AccW-1:0] RoundBias = AccW'(1) <<< (FracS - 1);
    localparam logic signed [AccW-1:0] SatMax    = (AccW'(1) <<< (StressW - 1)) - AccW'(1);
    localparam logic signed [AccW-1:0] SatMin    = -(AccW'(1) <<< (StressW - 1));

    typedef enum logic [0:0] {
        REG_LAMBDA = 1'b0,
        REG_SHEAR  = 1'b1
    } t_cfg_reg;

    typedef enum logic [1:0] {
        YS_IDLE,
        YS_MUL,
        YS_DIV
    } t_young_state;

    typedef struct packed {
        logic signed [StrainW-1:0] strain_xx;
        logic signed [StrainW-1:0] strain_yy;
        logic signed [StrainW-1:0] strain_zz;
        logic signed [StrainW-1:0] strain_xy;
        logic signed [StrainW-1:0] strain_yz;
        logic signed [StrainW-1:0] strain_zx;
        logic [CrackW-1:0]         crack_x;
        logic [CrackW-1:0]         crack_y;
        logic [CrackW-1:0]         crack_z;
        logic                      kind;
    } t_strain;

    typedef struct packed {
        logic signed [StressW-1:0] stress_xx;
        logic signed [StressW-1:0] stress_yy;
        logic signed [StressW-1:0] stress_zz;
        logic signed [StressW-1:0] stress_xy;
        logic signed [StressW-1:0] stress_yz;
        logic signed [StressW-1:0] stress_zx;
    } t_stress;

    typedef struct packed {
        logic [2:0] ok;
        logic       kind;
    } t_flags;

    typedef struct packed {
        logic s2;
        logic s3;
        logic s4;
        logic s5;
    } t_stage_en;

    typedef struct packed {
        logic signed [FullW-1:0] full;
        logic signed [CrkW-1:0]  crk;
        logic signed [CplW-1:0]  cpl;
        logic signed [CplW-1:0]  shr;
    } t_lane_out;

    // floor((acc + half lsb) / 2^30), clipped to the 32-bit range
    function automatic logic signed [StressW-1:0] round_sat(input logic signed [AccW-1:0] acc);
        logic signed [AccW-1:0] a;
        logic signed [AccW-1:0] q;
        logic signed [StressW-1:0] r;
        a = acc + RoundBias;
        q = a >>> FracS;
        if (q > SatMax) begin
            r = SatMax[StressW-1:0];
        end else if (q < SatMin) begin
            r = SatMin[StressW-1:0];
        end else begin
            r = q[StressW-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/isc_if.sv @@
// handshake channels: strain requests, stress results and register writes
`default_nettype none

interface isc_strain_if import isc_pkg::*; ();
    logic    valid;
    logic    ready;
    t_strain data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface isc_stress_if import isc_pkg::*; ();
    logic    valid;
    logic    ready;
    t_stress data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface isc_cfg_if import isc_pkg::*; ();
    logic            valid;
    logic            ready;
    t_cfg_reg        index;
    logic [ModW-1:0] wdata;
    modport source (output valid, output index, output wdata, input ready);
    modport sink   (input valid, input index, input wdata, output ready);
endinterface

`default_nettype wire

@@ rtl/isc_young.sv @@
// configuration registers and serial divider for the Q.16 Young's modulus
`default_nettype none

module isc_young import isc_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    isc_cfg_if.sink               i_cfg,
    output logic                  o_busy,
    output logic [ModW-1:0]       o_lam,
    output logic [ModW-1:0]       o_mu,
    output logic [C11W-1:0]       o_c11,
    output logic [E16W-1:0]       o_e16
);

    t_young_state         r_state, n_state;
    logic [ModW-1:0]      r_lam;
    logic [ModW-1:0]      r_mu;
    logic [C11W-1:0]      r_c11;
    logic [E16W-1:0]      r_e16;
    logic [DenW-1:0]      r_den;
    logic [DvdW-1:0]      r_dvd;
    logic [DenW-1:0]      r_rem;
    logic [E16W-1:0]      r_quo;
    logic [DivCntW-1:0]   r_cnt;

    logic                 cfg_wr;
    logic [NumW-1:0]      num;
    logic [C11W:0]        coef;
    logic [DenW:0]        rem_sh;
    logic                 ge;
    logic [DenW:0]        rem_nx;
    logic                 last;

    assign i_cfg.ready = 1'b1;
    assign cfg_wr      = i_cfg.valid & i_cfg.ready;

    // mu * (3 lambda + 2 mu)
    assign coef   = (C11W+1)'({r_lam, 1'b0}) + (C11W+1)'(r_lam) + (C11W+1)'({r_mu, 1'b0});
    assign num    = NumW'(r_mu) * NumW'(coef);

    // one restoring step per cycle, dividend msb first
    assign rem_sh = {r_rem, r_dvd[DvdW-1]};
    assign ge     = rem_sh >= (DenW+1)'(r_den);
    assign rem_nx = ge ? (rem_sh - (DenW+1)'(r_den)) : rem_sh;
    assign last   = r_cnt == DivCntW'(DvdW - 1);

    always_comb begin
        n_state = r_state;
        case (r_state)
            YS_IDLE: n_state = YS_IDLE;
            YS_MUL:  n_state = YS_DIV;
            YS_DIV:  n_state = last ? YS_IDLE : YS_DIV;
            default: n_state = YS_IDLE;
        endcase
        if (cfg_wr) begin
            n_state = YS_MUL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= YS_IDLE;
            r_lam   <= '0;
            r_mu    <= '0;
            r_c11   <= '0;
            r_e16   <= '0;
        end else begin
            r_state <= n_state;
            if (cfg_wr) begin
                case (i_cfg.index)
                    REG_LAMBDA: r_lam <= i_cfg.wdata;
                    REG_SHEAR:  r_mu  <= i_cfg.wdata;
                    default: ;
                endcase
            end
            if (r_state == YS_MUL) begin
                r_c11 <= C11W'({r_mu, 1'b0}) + C11W'(r_lam);
            end
            if (r_state == YS_DIV && last) begin
                r_e16 <= (r_den == '0) ? '0 : {r_quo[E16W-2:0], ge};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == YS_MUL) begin
            r_den <= DenW'(r_lam) + DenW'(r_mu);
            r_dvd <= {num, FracE'(0)};
            r_rem <= '0;
            r_quo <= '0;
            r_cnt <= '0;
        end else if (r_state == YS_DIV) begin
            r_dvd <= r_dvd << 1;
            r_rem <= rem_nx[DenW-1:0];
            r_quo <= {r_quo[E16W-2:0], ge};
            r_cnt <= r_cnt + DivCntW'(1);
        end
    end

    assign o_busy = r_state != YS_IDLE;
    assign o_lam  = r_lam;
    assign o_mu   = r_mu;
    assign o_c11  = r_c11;
    assign o_e16  = r_e16;

endmodule

`default_nettype wire

@@ rtl/isc_lane.sv @@
// one direction lane: diagonal, cracked diagonal, coupling and shear products
`default_nettype none

module isc_lane import isc_pkg::*; (
    input  wire logic                      i_clk,
    input  wire t_stage_en                 i_en,
    input  wire logic signed [StrainW-1:0] i_e_n,
    input  wire logic signed [StrainW-1:0] i_e_s,
    input  wire logic [CrackW-1:0]         i_crack,
    input  wire logic [E16W-1:0]           i_e16,
    input  wire logic [C11W-1:0]           i_c11,
    input  wire logic [ModW-1:0]           i_lam,
    input  wire logic [ModW-1:0]           i_mu,
    output t_lane_out                      o_out
);

    localparam int DProdW = CrackW + E16W;

    logic [DProdW-1:0]          d_prod;
    logic [StrainW-1:0]         mag;

    logic [E16W-1:0]            r_d16;
    logic [StrainW-1:0]         r_mag;
    logic                       r_neg2;
    logic signed [FullW-1:0]    r_full2;
    logic signed [CplW-1:0]     r_cpl2;
    logic signed [CplW-1:0]     r_shr2;

    logic [HiW-1:0]             r_hi;
    logic [LoW-1:0]             r_lo;
    logic                       r_neg3;
    logic signed [FullW-1:0]    r_full3;
    logic signed [CplW-1:0]     r_cpl3;
    logic signed [CplW-1:0]     r_shr3;

    logic [HiW-1:0]             crk_mag;
    logic signed [CrkW-1:0]     crk_s;

    // cracked diagonal modulus c * E, kept in Q.16
    assign d_prod = DProdW'(i_crack) * DProdW'(i_e16);
    assign mag    = i_e_n[StrainW-1] ? (~i_e_n + StrainW'(1)) : i_e_n;

    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r_d16   <= d_prod[FracE +: E16W];
            r_mag   <= mag;
            r_neg2  <= i_e_n[StrainW-1];
            r_full2 <= FullW'($signed({1'b0, i_c11})) * FullW'(i_e_n);
            r_cpl2  <= CplW'($signed({1'b0, i_lam})) * CplW'(i_e_n);
            r_shr2  <= CplW'($signed({1'b0, i_mu})) * CplW'(i_e_s);
        end
    end

    // split the wide modulus so each product stays within 32 bits a side
    always_ff @(posedge i_clk) begin
        if (i_en.s3) begin
            r_hi    <= HiW'(r_d16[E16W-1:FracE]) * HiW'(r_mag);
            r_lo    <= LoW'(r_d16[FracE-1:0]) * LoW'(r_mag);
            r_neg3  <= r_neg2;
            r_full3 <= r_full2;
            r_cpl3  <= r_cpl2;
            r_shr3  <= r_shr2;
        end
    end

    assign crk_mag   = r_hi + HiW'(r_lo[LoW-1:FracE]);
    assign crk_s     = $signed({1'b0, crk_mag});

    // truncates toward zero
    assign o_out.crk  = r_neg3 ? -crk_s : crk_s;
    assign o_out.full = r_full3;
    assign o_out.cpl  = r_cpl3;
    assign o_out.shr  = r_shr3;

endmodule

`default_nettype wire

@@ rtl/isc_merge.sv @@
// merge of lane products into stress sums, then rounding and clipping
`default_nettype none

module isc_merge import isc_pkg::*; (
    input  wire logic      i_clk,
    input  wire t_stage_en i_en,
    input  wire t_flags    i_flags,
    input  wire t_lane_out i_lane [3],
    output t_stress        o_stress
);

    logic signed [AccW-1:0]    n_acc [6];
    logic signed [AccW-1:0]    r_acc [6];
    logic signed [StressW-1:0] r_out [6];

    for (genvar g = 0; g < 3; g++) begin : g_sum
        localparam int J = (g + 1) % 3;
        localparam int K = (g + 2) % 3;
        logic signed [AccW-1:0] diag;
        logic signed [AccW-1:0] cpl_j;
        logic signed [AccW-1:0] cpl_k;
        logic                   shr_off;

        assign diag  = i_flags.ok[g] ? AccW'(i_lane[g].full) : AccW'(i_lane[g].crk);
        // coupling only between two uncracked directions
        assign cpl_j = (i_flags.ok[g] & i_flags.ok[J]) ? AccW'(i_lane[J].cpl) : '0;
        assign cpl_k = (i_flags.ok[g] & i_flags.ok[K]) ? AccW'(i_lane[K].cpl) : '0;
        assign n_acc[g] = diag + cpl_j + cpl_k;

        // plane g spans directions g and g+1
        assign shr_off    = i_flags.kind & ~(i_flags.ok[g] & i_flags.ok[J]);
        assign n_acc[g+3] = shr_off ? '0 : (AccW'(i_lane[g].shr) <<< 1);
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s4) begin
            r_acc <= n_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s5) begin
            for (int i = 0; i < 6; i++) begin
                r_out[i] <= round_sat(r_acc[i]);
            end
        end
    end

    assign o_stress.stress_xx = r_out[0];
    assign o_stress.stress_yy = r_out[1];
    assign o_stress.stress_zz = r_out[2];
    assign o_stress.stress_xy = r_out[3];
    assign o_stress.stress_yz = r_out[4];
    assign o_stress.stress_zx = r_out[5];

endmodule

`default_nettype wire

@@ rtl/isotropic_stress_with_cracking.sv @@
// top level: isotropic stress from strain with per-direction cracking
//
//   channel    dir   carries                                 taken when
//   i_cfg      in    register index, 24-bit modulus          valid & ready
//   i_strain   in    six strains, three crack factors, kind  valid & ready
//   o_stress   out   six saturated stresses                  valid & ready
//
// one request per cycle unless held; a result is offered once its request has passed
// five registers (input, two lane product stages, lane merge sum, round and clip).
// each stage holds while the one after it is full and cannot move on, so bubbles close
// up and a new request enters while a finished result waits on o_stress.ready.
// after every register write, i_strain.ready stays low while the shared serial divider
// rebuilds Young's modulus; reset needs no rebuild.
// reset is synchronous, active low; both moduli reset to 0.
`default_nettype none

module isotropic_stress_with_cracking import isc_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    isc_cfg_if.sink         i_cfg,
    isc_strain_if.sink      i_strain,
    isc_stress_if.source    o_stress
);

    logic                   busy;
    logic [ModW-1:0]        lam;
    logic [ModW-1:0]        mu;
    logic [C11W-1:0]        c11;
    logic [E16W-1:0]        e16;

    logic [4:0]             r_vld;
    logic [4:0]             rdy;
    t_stage_en              en;
    logic                   acc_in;

    t_strain                r_s1;
    t_flags                 n_f2;
    t_flags                 r_f2;
    t_flags                 r_f3;

    logic signed [StrainW-1:0] e_n [3];
    logic signed [StrainW-1:0] e_s [3];
    logic [CrackW-1:0]         crk [3];
    t_lane_out                 lane_out [3];

    isc_young u_young (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_busy  (busy),
        .o_lam   (lam),
        .o_mu    (mu),
        .o_c11   (c11),
        .o_e16   (e16)
    );

    // a stage may load when it is empty or its content moves on
    always_comb begin
        rdy[4] = ~r_vld[4] | o_stress.ready;
        for (int k = 3; k >= 0; k--) begin
            rdy[k] = ~r_vld[k] | rdy[k+1];
        end
    end

    assign en.s2 = rdy[1];
    assign en.s3 = rdy[2];
    assign en.s4 = rdy[3];
    assign en.s5 = rdy[4];

    assign i_strain.ready = rdy[0] & ~busy;
    assign acc_in         = i_strain.valid & i_strain.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (rdy[0]) begin
                r_vld[0] <= acc_in;
            end
            for (int k = 1; k < 5; k++) begin
                if (rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign n_f2.ok[0] = r_s1.crack_x >= Uncracked;
    assign n_f2.ok[1] = r_s1.crack_y >= Uncracked;
    assign n_f2.ok[2] = r_s1.crack_z >= Uncracked;
    assign n_f2.kind  = r_s1.kind;

    always_ff @(posedge i_clk) begin
        if (rdy[0]) begin
            r_s1 <= i_strain.data;
        end
        if (en.s2) begin
            r_f2 <= n_f2;
        end
        if (en.s3) begin
            r_f3 <= r_f2;
        end
    end

    assign e_n[0] = r_s1.strain_xx;
    assign e_n[1] = r_s1.strain_yy;
    assign e_n[2] = r_s1.strain_zz;
    assign e_s[0] = r_s1.strain_xy;
    assign e_s[1] = r_s1.strain_yz;
    assign e_s[2] = r_s1.strain_zx;
    assign crk[0] = r_s1.crack_x;
    assign crk[1] = r_s1.crack_y;
    assign crk[2] = r_s1.crack_z;

    for (genvar g = 0; g < 3; g++) begin : g_lane
        isc_lane u_lane (
            .i_clk   (i_clk),
            .i_en    (en),
            .i_e_n   (e_n[g]),
            .i_e_s   (e_s[g]),
            .i_crack (crk[g]),
            .i_e16   (e16),
            .i_c11   (c11),
            .i_lam   (lam),
            .i_mu    (mu),
            .o_out   (lane_out[g])
        );
    end

    isc_merge u_merge (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_flags  (r_f3),
        .i_lane   (lane_out),
        .o_stress (o_stress.data)
    );

    assign o_stress.valid = r_vld[4];

endmodule

`default_nettype wire

@@ tb/isc_stress_checker.sv @@
// checker for the isotropic stress block: predicts each stress result and compares it
module isc_stress_checker import isc_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_valid,
    input  logic            i_cfg_ready,
    input  t_cfg_reg        i_cfg_index,
    input  logic [ModW-1:0] i_cfg_wdata,
    input  logic            i_strain_valid,
    input  logic            i_strain_ready,
    input  t_strain         i_strain,
    input  logic            i_stress_valid,
    input  logic            i_stress_ready,
    input  t_stress         i_stress,
    output int              o_errors,
    output int              o_pending,
    output int              o_checked
);

    logic [ModW-1:0] lambda_q;
    logic [ModW-1:0] mu_q;
    t_stress         expected_stress[$];
    t_stress         want;
    logic [191:0]    got_bits;
    logic [191:0]    want_bits;
    int              n_errors = 0;
    int              n_checked = 0;
    string           field_name[6] = '{"stress_xx", "stress_yy", "stress_zz",
                                       "stress_xy", "stress_yz", "stress_zx"};

    task automatic report(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        n_errors++;
    endtask

    // floor((acc + half lsb) / 2^30), clipped to 32 bits
    function automatic logic signed [StressW-1:0] round_clip(input longint acc);
        longint q;
        q = (acc + 64'sd536870912) >>> FracS;
        if (q > 64'sd2147483647) begin
            q = 64'sd2147483647;
        end else if (q < -64'sd2147483648) begin
            q = -64'sd2147483648;
        end
        return q[31:0];
    endfunction

    // q.16 modulus times strain, truncated toward zero
    function automatic longint toward_zero(input longint modulus16, input longint strain);
        longint mag;
        longint t;
        mag = (strain < 0) ? -strain : strain;
        t = (modulus16 >>> 16) * mag + (((modulus16 & 64'hFFFF) * mag) >>> 16);
        return (strain < 0) ? -t : t;
    endfunction

    function automatic t_stress stress_of(input t_strain s, input logic [ModW-1:0] lam_r,
                                          input logic [ModW-1:0] mu_r);
        longint                    e[6];
        longint                    crack[3];
        bit                        intact[3];
        longint                    lam, mu, num, den, young16, c11, acc, g;
        logic signed [StressW-1:0] res[6];
        t_stress                   r;
        int                        i, j, b;
        lam = lam_r;
        mu  = mu_r;
        e[0] = $signed(s.strain_xx);
        e[1] = $signed(s.strain_yy);
        e[2] = $signed(s.strain_zz);
        e[3] = $signed(s.strain_xy);
        e[4] = $signed(s.strain_yz);
        e[5] = $signed(s.strain_zx);
        crack[0] = s.crack_x;
        crack[1] = s.crack_y;
        crack[2] = s.crack_z;
        for (i = 0; i < 3; i++) intact[i] = crack[i] >= 65536;
        num = mu * (3 * lam + 2 * mu);
        den = lam + mu;
        young16 = 0;
        if (den != 0) young16 = ((num / den) << 16) + (((num % den) << 16) / den);
        c11 = 2 * mu + lam;
        for (i = 0; i < 3; i++) begin
            acc = 0;
            for (j = 0; j < 3; j++) begin
                if (i == j) begin
                    if (intact[i]) acc += c11 * e[j];
                    else acc += toward_zero((crack[i] * young16) >>> 16, e[j]);
                end else if (intact[i] && intact[j]) begin
                    acc += lam * e[j];
                end
            end
            res[i] = round_clip(acc);
        end
        // shear planes xy, yz, zx
        for (i = 0; i < 3; i++) begin
            b = (i + 1) % 3;
            g = mu;
            if (s.kind && !(intact[i] && intact[b])) g = 0;
            res[3 + i] = round_clip(2 * g * e[3 + i]);
        end
        r.stress_xx = res[0];
        r.stress_yy = res[1];
        r.stress_zz = res[2];
        r.stress_xy = res[3];
        r.stress_yz = res[4];
        r.stress_zx = res[5];
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            lambda_q = '0;
            mu_q     = '0;
            expected_stress.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_LAMBDA: lambda_q = i_cfg_wdata;
                    REG_SHEAR:  mu_q = i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_stress_valid && i_stress_ready) begin
                if (expected_stress.size() == 0) begin
                    report($sformatf("stress result %h with no request waiting", i_stress));
                end else begin
                    want      = expected_stress.pop_front();
                    got_bits  = i_stress;
                    want_bits = want;
                    for (int f = 0; f < 6; f++) begin
                        if (got_bits[191 - 32 * f -: 32] !== want_bits[191 - 32 * f -: 32])
                            report($sformatf("%s got %0d expected %0d", field_name[f],
                                   $signed(got_bits[191 - 32 * f -: 32]),
                                   $signed(want_bits[191 - 32 * f -: 32])));
                    end
                    n_checked++;
                end
            end
            if (i_strain_valid && i_strain_ready)
                expected_stress.push_back(stress_of(i_strain, lambda_q, mu_q));
        end
        o_errors  <= n_errors;
        o_pending <= expected_stress.size();
        o_checked <= n_checked;
    end

endmodule

@@ tb/tb_isotropic_stress_with_cracking.sv @@
// testbench top: drives strain requests and register writes, gives the verdict
module tb_isotropic_stress_with_cracking;
    import isc_pkg::*;

    localparam int CycleLimit = 200000;
    localparam int Latency    = 5;
    localparam int PhaseItems = 170;
    localparam int HoldAt     = 490;
    localparam int HoldCycles = 150;

    localparam logic signed [StrainW-1:0] SMax = 32'sh7FFFFFFF;
    localparam logic signed [StrainW-1:0] SMin = 32'sh80000000;
    localparam logic [CrackW-1:0]         Half = 17'd32768;

    logic clk;
    logic rst_n;
    int   errors;
    int   pending;
    int   checked;
    int   cycles = 0;
    int   n_sent = 0;
    int   n_cracked = 0;
    int   n_settings = 0;
    bit   idle_on = 1'b1;
    bit   held_once = 1'b0;

    logic [ModW-1:0] lam_set[6];
    logic [ModW-1:0] mu_set[6];

    isc_cfg_if    cfg_if();
    isc_strain_if strain_if();
    isc_stress_if stress_if();

    isotropic_stress_with_cracking DUT (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_cfg    (cfg_if),
        .i_strain (strain_if),
        .o_stress (stress_if)
    );

    isc_stress_checker u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_valid    (cfg_if.valid),
        .i_cfg_ready    (cfg_if.ready),
        .i_cfg_index    (cfg_if.index),
        .i_cfg_wdata    (cfg_if.wdata),
        .i_strain_valid (strain_if.valid),
        .i_strain_ready (strain_if.ready),
        .i_strain       (strain_if.data),
        .i_stress_valid (stress_if.valid),
        .i_stress_ready (stress_if.ready),
        .i_stress       (stress_if.data),
        .o_errors       (errors),
        .o_pending      (pending),
        .o_checked      (checked)
    );

    initial clk = 1'b0;
    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CycleLimit) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
            $display("isotropic_stress_with_cracking regression: fail");
            $finish;
        end
    end

    // result side: random stalls plus one long hold-off so the pipe backs up
    initial begin
        stress_if.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (!held_once && checked >= HoldAt) begin
                held_once = 1'b1;
                stress_if.ready <= 1'b0;
                repeat (HoldCycles) @(posedge clk);
            end
            stress_if.ready <= !(idle_on && ($urandom_range(99) < 37));
        end
    end

    function automatic t_strain strain_req(
        input logic signed [StrainW-1:0] xx, yy, zz, xy, yz, zx,
        input logic [CrackW-1:0] cx, cy, cz, input logic k);
        t_strain s;
        s.strain_xx = xx;
        s.strain_yy = yy;
        s.strain_zz = zz;
        s.strain_xy = xy;
        s.strain_yz = yz;
        s.strain_zx = zx;
        s.crack_x   = cx;
        s.crack_y   = cy;
        s.crack_z   = cz;
        s.kind      = k;
        return s;
    endfunction

    function automatic logic signed [StrainW-1:0] pick_strain();
        case ($urandom_range(9))
            0: return SMax;
            1: return SMin;
            2, 3, 4: return $urandom;
            default: return 32'($urandom_range(2097152)) - 32'd1048576;
        endcase
    endfunction

    function automatic logic [CrackW-1:0] pick_crack();
        case ($urandom_range(19))
            10, 11, 12, 13, 14, 15: return 17'($urandom_range(65535));
            16: return '0;
            17: return 17'd65535;
            18: return 17'($urandom_range(131071, 65537));
            19: return 17'd1;
            default: return Uncracked;
        endcase
    endfunction

    function automatic t_strain random_strain();
        return strain_req(pick_strain(), pick_strain(), pick_strain(), pick_strain(),
                          pick_strain(), pick_strain(), pick_crack(), pick_crack(),
                          pick_crack(), 1'($urandom_range(1)));
    endfunction

    // leaves valid high; the caller lowers it when the burst is over
    task automatic offer_strain(input t_strain s);
        while (idle_on && ($urandom_range(99) < 37)) begin
            strain_if.valid <= 1'b0;
            @(posedge clk);
        end
        strain_if.valid <= 1'b1;
        strain_if.data  <= s;
        do @(posedge clk); while (!strain_if.ready);
        n_sent++;
        if (s.crack_x < Uncracked || s.crack_y < Uncracked || s.crack_z < Uncracked)
            n_cracked++;
    endtask

    task automatic write_reg(input t_cfg_reg idx, input logic [ModW-1:0] value);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.wdata <= value;
        do @(posedge clk); while (!cfg_if.ready);
    endtask

    task automatic set_moduli(input logic [ModW-1:0] lam, input logic [ModW-1:0] mu);
        write_reg(REG_LAMBDA, lam);
        write_reg(REG_SHEAR, mu);
        cfg_if.valid <= 1'b0;
        n_settings++;
    endtask

    task automatic drain_stress();
        do @(posedge clk); while (pending != 0);
    endtask

    initial begin
        cfg_if.valid    <= 1'b0;
        cfg_if.index    <= REG_LAMBDA;
        cfg_if.wdata    <= '0;
        strain_if.valid <= 1'b0;
        strain_if.data  <= '0;
        rst_n           <= 1'b0;
        lam_set = '{24'hFFFFFF, 24'h000000, 24'hFFFFFF, 24'(0), 24'(0), 24'h000000};
        mu_set  = '{24'hFFFFFF, 24'hFFFFFF, 24'h000000, 24'(0), 24'(0), 24'h000000};
        lam_set[3] = 24'($urandom);
        mu_set[3]  = 24'($urandom);
        lam_set[4] = 24'($urandom_range(4095));
        mu_set[4]  = 24'($urandom_range(4095));
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // moduli still at reset: zero denominator, so cracked diagonals vanish
        offer_strain(strain_req(SMax, SMin, 32'sd12345, 1, -1, SMax,
                                Uncracked, Uncracked, Uncracked, 1'b0));
        offer_strain(strain_req(SMax, SMin, -32'sd777, SMin, SMax, 7,
                                Half, '0, 17'd65535, 1'b1));
        offer_strain(strain_req(SMin, SMin, SMin, SMin, SMin, SMin,
                                Half, Half, Half, 1'b0));
        strain_if.valid <= 1'b0;
        drain_stress();
        n_settings++;

        set_moduli(24'd1500000, 24'd3000000);
        offer_strain(strain_req(0, 0, 0, 0, 0, 0, Uncracked, Uncracked, Uncracked, 1'b0));
        offer_strain(strain_req(SMax, SMax, SMax, SMax, SMax, SMax,
                                Uncracked, Uncracked, Uncracked, 1'b0));
        offer_strain(strain_req(SMin, SMin, SMin, SMin, SMin, SMin,
                                Uncracked, Uncracked, Uncracked, 1'b1));
        offer_strain(strain_req(SMax, SMin, 1, -1, SMax, SMin,
                                Uncracked, Uncracked, Uncracked, 1'b0));
        // one direction cracked at a time, in both modes
        for (int d = 0; d < 3; d++) begin
            for (int k = 0; k < 2; k++) begin
                offer_strain(strain_req(-32'sd300000000, 32'sd200000000, -32'sd123456789,
                                        32'sd50000000, -32'sd60000000, 32'sd70000000,
                                        (d == 0) ? Half : Uncracked,
                                        (d == 1) ? Half : Uncracked,
                                        (d == 2) ? Half : Uncracked, 1'(k)));
            end
        end
        offer_strain(strain_req(SMax, SMin, SMax, SMin, SMax, SMin, '0, '0, '0, 1'b1));
        offer_strain(strain_req(-32'sd5, -32'sd1073741824, SMin, -32'sd3, SMin, -32'sd1,
                                17'd65535, 17'd65535, 17'd65535, 1'b1));
        // factors above one still count as uncracked
        offer_strain(strain_req(32'sd1073741824, SMin, SMax, SMax, SMin, 32'sd9,
                                17'd65537, 17'd131071, Uncracked, 1'b1));
        offer_strain(strain_req(SMin, 32'sd99, -32'sd99, SMin, 1, SMax,
                                17'd1, Uncracked, Uncracked, 1'b1));
        offer_strain(strain_req(32'sd400000000, -32'sd400000000, 32'sd3, SMax, SMax, SMax,
                                Half, 17'd40000, Uncracked, 1'b1));
        offer_strain(strain_req(1, -1, 1, -1, 1, -1, Uncracked, Uncracked, Uncracked, 1'b0));
        strain_if.valid <= 1'b0;
        drain_stress();

        for (int p = 0; p < 6; p++) begin
            set_moduli(lam_set[p], mu_set[p]);
            idle_on = (p != 1);
            for (int k = 0; k < PhaseItems; k++) begin
                // sender pause until every outstanding request has its result
                if (p == 2 && k == 100) begin
                    strain_if.valid <= 1'b0;
                    drain_stress();
                end
                offer_strain(random_strain());
            end
            strain_if.valid <= 1'b0;
            drain_stress();
        end
        idle_on = 1'b1;

        repeat (4 * Latency) @(posedge clk);
        $display("covered %0d strain requests under %0d modulus settings, %0d with a crack",
                 n_sent, n_settings, n_cracked);
        $display("compared %0d stress results field by field, %0d mismatches", checked, errors);
        if (errors == 0) begin
            $display("isotropic_stress_with_cracking regression: pass");
        end else begin
            $display("isotropic_stress_with_cracking regression: fail");
        end
        $finish;
    end

endmodule
